// ----- design/cbm_pkg.sv -----
// Shared types and constants for the cartridge bank mapper.
// Action codes, map targets and CPU register page decode values.
// No dependencies.
`timescale 1ns / 1ps

package cbm_pkg;

   typedef enum logic [1:0] {
      ACT_CPU_WRITE = 2'd0,
      ACT_CPU_READ  = 2'd1,
      ACT_PPU_MAP   = 2'd2,
      ACT_TICK      = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      TGT_NONE   = 3'd0,
      TGT_PRG    = 3'd1,
      TGT_WRAM   = 3'd2,
      TGT_CHR    = 3'd3,
      TGT_CHRRAM = 3'd4,
      TGT_NTRAM  = 3'd5
   } map_target_type;

   // CPU register pages: address[15:11]
   localparam logic [4:0] PAGE_IRQ_LO  = 5'h0A;   // 5000
   localparam logic [4:0] PAGE_IRQ_HI  = 5'h0B;   // 5800
   localparam logic [4:0] PAGE_PRG0    = 5'h1C;   // E000
   localparam logic [4:0] PAGE_PRG1    = 5'h1D;   // E800
   localparam logic [4:0] PAGE_PRG2    = 5'h1E;   // F000
   localparam logic [4:0] PAGE_PROTECT = 5'h1F;   // F800

   localparam logic [1:0] PAGE_CHR_TOP = 2'b10;   // 8000-BFFF
   localparam logic [2:0] PAGE_NT_TOP  = 3'b110;  // C000-DFFF

   localparam logic [7:0] RAM_SELECT_MIN = 8'hE0;
   localparam logic [7:0] PRG_BANK_MASK  = 8'h3F;
   localparam logic [7:0] PRG_FIXED_BANK = 8'h3F;

   typedef struct packed {
      action_type  action;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_item_type;

endpackage

// ----- design/cartridge_bank_mapper_with_irq.sv -----
// Cartridge bank mapper: register file, IRQ counter and address translation.
// Depends on cbm_pkg.
// An accepted request is held in the input register, then moves on to the result register, which drives rsp valid.
// Throughput: one item per cycle while the result is taken; with the result stalled, one more item waits in the
// input register. All state updates take place as an item passes to the result register.
// Reset (synchronous, active high) clears all banks, protect byte, counter and IRQ.
`timescale 1ns / 1ps

module cartridge_bank_mapper_with_irq
   import cbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_line,
   output logic [2:0]  rsp_map_target,
   output logic [7:0]  rsp_map_bank,
   output logic [12:0] rsp_map_offset
);

   // pipeline control
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   logic         advance;

   // mapper state
   logic [7:0]  prg_ff [3];
   logic [7:0]  prg_in [3];
   logic [7:0]  chr_ff [8];
   logic [7:0]  chr_in [8];
   logic [7:0]  nt_ff  [4];
   logic [7:0]  nt_in  [4];
   logic [7:0]  protect_ff, protect_in;
   logic [15:0] irq_count_ff, irq_count_in;
   logic        irq_pending_ff, irq_pending_in;

   // result register
   logic [7:0]     read_data_ff, read_data_in;
   map_target_type target_ff, target_in;
   logic [7:0]     bank_ff, bank_in;
   logic [12:0]    offset_ff, offset_in;
   logic           irq_line_ff;

   logic [4:0]  page;
   logic [3:0]  ppu_slot;
   logic [7:0]  chr_val;
   logic [7:0]  nt_val;
   logic        ram_off;
   logic [15:0] count_inc;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff.action     <= action_type'(req_action);
         s1_item_ff.address    <= req_address;
         s1_item_ff.write_data <= req_write_data;
      end
   end

   assign page      = s1_item_ff.address[15:11];
   assign ppu_slot  = s1_item_ff.address[13:10];
   assign chr_val   = chr_ff[ppu_slot[2:0]];
   assign nt_val    = nt_ff[ppu_slot[1:0]];
   assign ram_off   = ppu_slot[2] ? prg_ff[1][7] : prg_ff[1][6];
   assign count_inc = irq_count_ff + 16'd1;

   // state next values
   always_comb begin
      prg_in         = prg_ff;
      chr_in         = chr_ff;
      nt_in          = nt_ff;
      protect_in     = protect_ff;
      irq_count_in   = irq_count_ff;
      irq_pending_in = irq_pending_ff;
      case (s1_item_ff.action)
         ACT_CPU_WRITE: begin
            case (page)
               PAGE_IRQ_LO: begin
                  irq_count_in[7:0] = s1_item_ff.write_data;
                  irq_pending_in    = 1'b0;
               end
               PAGE_IRQ_HI: begin
                  irq_count_in[15:8] = s1_item_ff.write_data;
                  irq_pending_in     = 1'b0;
               end
               PAGE_PRG0:    prg_in[0] = s1_item_ff.write_data;
               PAGE_PRG1:    prg_in[1] = s1_item_ff.write_data;
               PAGE_PRG2:    prg_in[2] = s1_item_ff.write_data & PRG_BANK_MASK;
               PAGE_PROTECT: protect_in = s1_item_ff.write_data;
               default: begin
                  if (page[4:3] == PAGE_CHR_TOP) begin
                     chr_in[page[2:0]] = s1_item_ff.write_data;
                  end else if (page[4:2] == PAGE_NT_TOP) begin
                     nt_in[page[1:0]] = s1_item_ff.write_data;
                  end
               end
            endcase
         end
         ACT_CPU_READ: begin
            if (page == PAGE_IRQ_LO || page == PAGE_IRQ_HI) begin
               irq_pending_in = 1'b0;
            end
         end
         ACT_TICK: begin
            if (irq_count_ff[15]) begin
               irq_count_in = count_inc;
               if (count_inc == 16'd0) begin
                  irq_pending_in = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // result computation; CPU map never depends on the same item's write
   always_comb begin
      read_data_in = 8'd0;
      target_in    = TGT_NONE;
      bank_in      = 8'd0;
      offset_in    = 13'd0;
      case (s1_item_ff.action)
         ACT_CPU_WRITE, ACT_CPU_READ: begin
            if (s1_item_ff.action == ACT_CPU_READ) begin
               case (page)
                  PAGE_IRQ_LO: read_data_in = irq_count_ff[7:0];
                  PAGE_IRQ_HI: read_data_in = irq_count_ff[15:8];
                  default:     read_data_in = s1_item_ff.address[15:8];
               endcase
            end
            if (s1_item_ff.address[15]) begin
               target_in = TGT_PRG;
               offset_in = s1_item_ff.address[12:0];
               case (s1_item_ff.address[14:13])
                  2'd0:    bank_in = prg_ff[0] & PRG_BANK_MASK;
                  2'd1:    bank_in = prg_ff[1] & PRG_BANK_MASK;
                  2'd2:    bank_in = prg_ff[2] & PRG_BANK_MASK;
                  default: bank_in = PRG_FIXED_BANK;
               endcase
            end else if (s1_item_ff.address[14:13] == 2'b11) begin
               target_in = TGT_WRAM;
               offset_in = s1_item_ff.address[12:0];
            end
         end
         ACT_PPU_MAP: begin
            offset_in = {3'd0, s1_item_ff.address[9:0]};
            if (!ppu_slot[3]) begin
               if (chr_val >= RAM_SELECT_MIN && !ram_off) begin
                  target_in = TGT_CHRRAM;
                  bank_in   = {3'd0, chr_val[4:0]};
               end else begin
                  target_in = TGT_CHR;
                  bank_in   = chr_val;
               end
            end else begin
               if (nt_val >= RAM_SELECT_MIN) begin
                  target_in = TGT_NTRAM;
                  bank_in   = {7'd0, nt_val[0]};
               end else begin
                  target_in = TGT_CHR;
                  bank_in   = nt_val;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_ff         <= '{default: 8'd0};
         chr_ff         <= '{default: 8'd0};
         nt_ff          <= '{default: 8'd0};
         protect_ff     <= 8'd0;
         irq_count_ff   <= 16'd0;
         irq_pending_ff <= 1'b0;
      end else if (advance) begin
         prg_ff         <= prg_in;
         chr_ff         <= chr_in;
         nt_ff          <= nt_in;
         protect_ff     <= protect_in;
         irq_count_ff   <= irq_count_in;
         irq_pending_ff <= irq_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff <= read_data_in;
         irq_line_ff  <= irq_pending_in;
         target_ff    <= target_in;
         bank_ff      <= bank_in;
         offset_ff    <= offset_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = read_data_ff;
   assign rsp_irq_line   = irq_line_ff;
   assign rsp_map_target = target_ff;
   assign rsp_map_bank   = bank_ff;
   assign rsp_map_offset = offset_ff;

   // an empty result register must never stall the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("req_ready low with empty result register");

   // the reported IRQ line matches the pending flag left by that item
   a_irq_line_tracks: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_irq_line == irq_pending_ff)
      else $error("irq line disagrees with pending flag");

   // counter wrap on a tick raises the IRQ
   a_wrap_raises_irq: assert property (@(posedge clock) disable iff (reset)
      advance && s1_item_ff.action == ACT_TICK && irq_count_ff == 16'hFFFF
      |=> irq_pending_ff && irq_count_ff == 16'd0)
      else $error("counter wrap did not raise irq");

   // counter byte writes clear the IRQ
   a_write_clears_irq: assert property (@(posedge clock) disable iff (reset)
      advance && s1_item_ff.action == ACT_CPU_WRITE
      && (page == PAGE_IRQ_LO || page == PAGE_IRQ_HI)
      |=> !irq_pending_ff)
      else $error("counter write left irq pending");

endmodule
